// File: sv/trig_series_fit_and_eval_macros.svh
// Assertion macros shared by the trig series fit and evaluate block.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef TRIG_SERIES_FIT_AND_EVAL_MACROS_SVH
`define TRIG_SERIES_FIT_AND_EVAL_MACROS_SVH

// same-cycle implication
`define TSFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tsfe_pkg.sv
// Types, constants and the quarter-wave sine table for the trig series block.
// No dependencies; used by tsfe_ctrl, tsfe_datapath and the top level.
package tsfe_pkg;

    localparam int MAX_HARMONICS    = 31;
    localparam int MEM_DEPTH        = MAX_HARMONICS + 1;
    localparam int HARM_W           = $clog2(MEM_DEPTH);
    localparam int MAX_NODES_DEF    = 1024;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER_W        = SINE_IDX_W - 2;
    localparam int QUARTER_N        = SINE_TABLE_DEPTH / 4;
    localparam int PHASE_W          = 16;
    localparam int TRIG_W           = 18;
    localparam int DATA_W           = 32;
    localparam int SUM_W            = 64;
    localparam int PROD_W           = DATA_W + TRIG_W;
    localparam int COEF_SHIFT       = 15;
    localparam int DIV_RADIX_BITS   = 4;
    localparam int DIV_BITS         =
        ((SUM_W - COEF_SHIFT + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS) * DIV_RADIX_BITS;
    localparam int DIV_STEPS        = DIV_BITS / DIV_RADIX_BITS;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W        = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HARMONICS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_WIDTH  = 2'd2;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;

    localparam logic [DATA_W-1:0]  INV_WIDTH_RESET    = 32'h0001_0000;
    localparam logic [PHASE_W-1:0] PHASE_HALF_TURN    = 16'h8000;
    localparam logic [PHASE_W-1:0] PHASE_QUARTER_TURN = 16'h4000;
    localparam logic signed [TRIG_W-1:0] A0_WEIGHT    = 18'sd32768;
    localparam logic [DATA_W-1:0]  SAT_MAX            = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  SAT_MIN            = 32'h8000_0000;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     error;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic map;
        logic add_a;
        logic add_b;
        logic next_k;
        logic count_inc;
        logic ev_rd;
        logic div_load;
        logic div_step;
        logic mul;
        logic acc;
        logic sel_sin;
        logic fin;
        logic fin_err;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic eval_err;
        logic k_last;
        logic k_zero;
        logic div_last;
        logic out_free;
    } ctrl_status_t;

    typedef logic signed [TRIG_W-1:0] qsine_tab_t [QUARTER_N];

    function automatic logic [63:0] quarter_sine(input logic [63:0] theta);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        int          j;
        x2 = (theta * theta) >> 30;
        t  = Q30_ONE;
        for (j = 0; j < 6; j++) begin
            p = (x2 * t) >> 30;
            case (j)
                0:       t = Q30_ONE - p / 156;
                1:       t = Q30_ONE - p / 110;
                2:       t = Q30_ONE - p / 72;
                3:       t = Q30_ONE - p / 42;
                4:       t = Q30_ONE - p / 20;
                default: t = Q30_ONE - p / 6;
            endcase
        end
        return (theta * t) >> 30;
    endfunction

    function automatic logic signed [TRIG_W-1:0] qsine_entry(input int j);
        logic [63:0] r;
        logic [63:0] theta;
        logic [63:0] s;
        r     = 64'(j) << (30 - QUARTER_W);
        theta = (r * HALF_PI_Q30) >> 30;
        s     = (quarter_sine(theta) + 64'd8192) >> 14;
        return TRIG_W'(s);
    endfunction

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t tab;
        int         j;
        for (j = 0; j < QUARTER_N; j++) begin
            tab[j] = qsine_entry(j);
        end
        return tab;
    endfunction

    localparam qsine_tab_t QSINE = build_qsine();
    localparam logic signed [TRIG_W-1:0] QSINE_PEAK = qsine_entry(QUARTER_N);

    function automatic logic signed [TRIG_W-1:0] sine_lookup(input logic [PHASE_W-1:0] phase);
        logic [SINE_IDX_W-1:0]      idx;
        logic [1:0]                 quad;
        logic [QUARTER_W-1:0]       off;
        logic signed [TRIG_W-1:0]   mag;
        idx  = phase[PHASE_W-1 -: SINE_IDX_W];
        quad = idx[SINE_IDX_W-1 -: 2];
        off  = idx[QUARTER_W-1:0];
        if (!quad[0]) begin
            mag = QSINE[off];
        end
        else if (off == '0) begin
            mag = QSINE_PEAK;
        end
        else begin
            mag = QSINE[QUARTER_W'(~off + 1'b1)];
        end
        return quad[1] ? -mag : mag;
    endfunction

endpackage

// File: sv/tsfe_ctrl.sv
// Sequencer for the trig series block: walks harmonics for add and evaluate.
// Depends on tsfe_pkg for command, status and item kind codes.
module tsfe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             in_kind,
    input  tsfe_pkg::ctrl_status_t status,
    output tsfe_pkg::ctrl_cmd_t    cmd
);
    import tsfe_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MAP_ADD = 4'd1;
    localparam logic [3:0] S_ADD_A   = 4'd2;
    localparam logic [3:0] S_ADD_B   = 4'd3;
    localparam logic [3:0] S_MAP_EV  = 4'd4;
    localparam logic [3:0] S_EV_RD   = 4'd5;
    localparam logic [3:0] S_EV_LOAD = 4'd6;
    localparam logic [3:0] S_EV_DIV  = 4'd7;
    localparam logic [3:0] S_EV_MUL  = 4'd8;
    localparam logic [3:0] S_EV_ACC  = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       sel_reg;
    logic       sel_next;
    logic       err_reg;
    logic       err_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        err_next   = err_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (in_kind)
                        KIND_CLEAR: cmd.clear = 1'b1;
                        KIND_ADD:
                        begin
                            if (!status.full)
                            begin
                                state_next = S_MAP_ADD;
                            end
                        end
                        KIND_EVAL:
                        begin
                            err_next   = status.eval_err;
                            state_next = status.eval_err ? S_FIN : S_MAP_EV;
                        end
                        default: ;
                    endcase
                end
            end
            S_MAP_ADD:
            begin
                cmd.map    = 1'b1;
                state_next = S_ADD_A;
            end
            S_ADD_A:
            begin
                cmd.add_a  = 1'b1;
                state_next = S_ADD_B;
            end
            S_ADD_B:
            begin
                cmd.add_b  = 1'b1;
                cmd.next_k = 1'b1;
                if (status.k_last)
                begin
                    cmd.count_inc = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_ADD_A;
                end
            end
            S_MAP_EV:
            begin
                cmd.map    = 1'b1;
                state_next = S_EV_RD;
            end
            S_EV_RD:
            begin
                cmd.ev_rd  = 1'b1;
                sel_next   = 1'b0;
                state_next = S_EV_LOAD;
            end
            S_EV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_EV_DIV;
            end
            S_EV_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_EV_MUL;
                end
            end
            S_EV_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EV_ACC;
            end
            S_EV_ACC:
            begin
                cmd.acc = 1'b1;
                if (!sel_reg && !status.k_zero)
                begin
                    sel_next   = 1'b1;
                    state_next = S_EV_LOAD;
                end
                else if (status.k_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.next_k = 1'b1;
                    state_next = S_EV_RD;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.fin     = 1'b1;
                    cmd.fin_err = err_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        cmd.sel_sin = sel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            err_reg   <= err_next;
        end
    end

endmodule

// File: sv/tsfe_datapath.sv
// Datapath for the trig series block: config registers, sum store, phase map,
// multiplier, radix-16 divider, accumulator and output word register.
// Depends on tsfe_pkg and trig_series_fit_and_eval_macros.svh.
`include "trig_series_fit_and_eval_macros.svh"

module tsfe_datapath #(
    parameter int MAX_NODES = tsfe_pkg::MAX_NODES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsfe_pkg::DATA_W-1:0]     cfg_data,
    input  tsfe_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tsfe_pkg::out_item_t             out_data,
    input  tsfe_pkg::ctrl_cmd_t             cmd,
    output tsfe_pkg::ctrl_status_t          status
);
    import tsfe_pkg::*;

    localparam int NW = $clog2(MAX_NODES + 1);

    logic [HARM_W-1:0]        harm_reg;
    logic signed [DATA_W-1:0] start_reg;
    logic [DATA_W-1:0]        invw_reg;

    logic signed [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0]        d_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [PHASE_W-1:0]       pk_reg;
    logic [HARM_W-1:0]        k_reg;

    logic [SUM_W-1:0]         cos_mem [MEM_DEPTH];
    logic [SUM_W-1:0]         sin_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]     vld_reg;
    logic [SUM_W-1:0]         rd_cos_reg;
    logic [SUM_W-1:0]         rd_sin_reg;
    logic                     rd_vld_reg;

    logic signed [TRIG_W-1:0] tab_c_reg;
    logic signed [TRIG_W-1:0] tab_s_reg;
    logic signed [PROD_W-1:0] prod_a_reg;
    logic signed [PROD_W-1:0] prod_b_reg;

    logic [DIV_BITS-1:0]      dq_reg;
    logic [DIV_BITS-1:0]      dq_next;
    logic [NW-1:0]            rem_reg;
    logic [NW-1:0]            rem_next;
    logic [DIV_CNT_W-1:0]     dcnt_reg;
    logic                     neg_reg;

    logic signed [SUM_W-1:0]  acc_reg;
    logic [NW-1:0]            count_reg;

    logic signed [DATA_W-1:0] value_reg;
    logic                     error_reg;
    logic                     out_valid_reg;

    logic [DATA_W-1:0]        map_prod;
    logic signed [TRIG_W-1:0] cos_t;
    logic signed [TRIG_W-1:0] sin_t;
    logic signed [TRIG_W-1:0] tab_sel;
    logic signed [DATA_W-1:0] coef;
    logic signed [DATA_W-1:0] mul_x;
    logic signed [TRIG_W-1:0] mul_t;
    logic signed [PROD_W-1:0] prod_a;
    logic signed [PROD_W-1:0] prod_b;
    logic [SUM_W-1:0]         cos_rd;
    logic [SUM_W-1:0]         sin_rd;
    logic [SUM_W-1:0]         sum_sel;
    logic [SUM_W-1:0]         sum_mag;
    logic [NW-1:0]            half_n;
    logic                     out_free;
    logic                     acc_fits;
    logic signed [DATA_W-1:0] value_sat;

    assign map_prod = d_reg * invw_reg;
    assign cos_t    = sine_lookup(pk_reg + PHASE_QUARTER_TURN);
    assign sin_t    = sine_lookup(pk_reg);

    assign cos_rd  = rd_vld_reg ? rd_cos_reg : '0;
    assign sin_rd  = rd_vld_reg ? rd_sin_reg : '0;
    assign sum_sel = cmd.sel_sin ? sin_rd : cos_rd;
    assign sum_mag = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;

    always_comb
    begin
        if (|dq_reg[DIV_BITS-1:DATA_W-1])
        begin
            coef = neg_reg ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            coef = neg_reg ? -$signed(dq_reg[DATA_W-1:0]) : $signed(dq_reg[DATA_W-1:0]);
        end
    end

    assign tab_sel = (k_reg == '0) ? A0_WEIGHT : (cmd.sel_sin ? tab_s_reg : tab_c_reg);
    assign mul_x   = cmd.mul ? coef : y_reg;
    assign mul_t   = cmd.mul ? tab_sel : cos_t;
    assign prod_a  = mul_x * mul_t;
    assign prod_b  = y_reg * sin_t;

    always_comb
    begin
        logic [NW:0]          trial;
        logic [NW-1:0]        r;
        logic [DIV_BITS-1:0]  q;
        int                   i;
        r = rem_reg;
        q = dq_reg;
        for (i = 0; i < DIV_RADIX_BITS; i++)
        begin
            trial = {r, q[DIV_BITS-1]};
            q     = {q[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, count_reg})
            begin
                trial = trial - {1'b0, count_reg};
                q[0]  = 1'b1;
            end
            r = trial[NW-1:0];
        end
        dq_next  = q;
        rem_next = r;
    end

    assign acc_fits  = (acc_reg[SUM_W-1:47] == '0) || (acc_reg[SUM_W-1:47] == '1);
    assign value_sat = acc_fits ? acc_reg[47:16] : (acc_reg[SUM_W-1] ? SAT_MIN : SAT_MAX);

    assign half_n   = (count_reg - 1'b1) >> 1;
    assign out_free = !out_valid_reg || out_ready;

    assign status.full     = (count_reg >= NW'(MAX_NODES));
    assign status.eval_err = (count_reg == '0) || (32'(harm_reg) > 32'(half_n));
    assign status.k_last   = (k_reg == harm_reg);
    assign status.k_zero   = (k_reg == '0);
    assign status.div_last = (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.out_free = out_free;

    assign out_valid      = out_valid_reg;
    assign out_data.value = value_reg;
    assign out_data.error = error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            harm_reg  <= '0;
            start_reg <= '0;
            invw_reg  <= INV_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HARMONICS:      harm_reg  <= cfg_data[HARM_W-1:0];
                REG_INTERVAL_START: start_reg <= cfg_data;
                REG_INVERSE_WIDTH:  invw_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                vld_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.add_b)
                begin
                    vld_reg[k_reg] <= 1'b1;
                end
                if (cmd.count_inc)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_a || cmd.ev_rd)
        begin
            rd_cos_reg <= cos_mem[k_reg];
            rd_sin_reg <= sin_mem[k_reg];
            rd_vld_reg <= vld_reg[k_reg];
        end
        if (cmd.add_b)
        begin
            cos_mem[k_reg] <= cos_rd + SUM_W'(prod_a_reg);
            sin_mem[k_reg] <= sin_rd + SUM_W'(prod_b_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            y_reg <= in_data.y;
            d_reg <= in_data.x - start_reg;
        end
        if (cmd.map)
        begin
            phase_reg <= map_prod[DATA_W-1:PHASE_W] ^ PHASE_HALF_TURN;
            pk_reg    <= '0;
            k_reg     <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            if (cmd.next_k)
            begin
                pk_reg <= pk_reg + phase_reg;
                k_reg  <= k_reg + 1'b1;
            end
            if (cmd.acc)
            begin
                acc_reg <= acc_reg + SUM_W'(prod_a_reg);
            end
        end
        if (cmd.ev_rd)
        begin
            tab_c_reg <= cos_t;
            tab_s_reg <= sin_t;
        end
        if (cmd.add_a || cmd.mul)
        begin
            prod_a_reg <= prod_a;
        end
        if (cmd.add_a)
        begin
            prod_b_reg <= prod_b;
        end
        if (cmd.div_load)
        begin
            dq_reg   <= DIV_BITS'(sum_mag[SUM_W-1:COEF_SHIFT]);
            rem_reg  <= '0;
            dcnt_reg <= '0;
            neg_reg  <= sum_sel[SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            dq_reg   <= dq_next;
            rem_reg  <= rem_next;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.fin)
        begin
            value_reg <= cmd.fin_err ? '0 : value_sat;
            error_reg <= cmd.fin_err;
        end
    end

    `TSFE_ASSERT_NOW(a_fin_slot, cmd.fin, out_free, "result overwrites a pending word")
    `TSFE_ASSERT_NOW(a_div_nonzero, cmd.div_load, count_reg != '0, "divide by empty node count")
    `TSFE_ASSERT_NOW(a_add_room, cmd.count_inc, !status.full, "node added to a full store")
    `TSFE_ASSERT_NEXT(a_count_step, cmd.count_inc, count_reg == $past(count_reg) + 1'b1, "node count did not advance")

endmodule

// File: sv/trig_series_fit_and_eval.sv
// Top level of the trig series fit and evaluate block.
// Depends on tsfe_pkg, tsfe_ctrl and tsfe_datapath.
//
// Fits a truncated Fourier series to supplied samples and evaluates it, Q16.16 values.
// One word at a time: clear and unknown kinds are handled in the idle state; an add
// steps through the harmonics, each through the read-multiply-write of the sum
// store; an evaluate forms each coefficient in the divider at four quotient bits a
// cycle, and goes straight to the result when it reports an error. A finished
// result waits in the output register while the next input word is taken.
module trig_series_fit_and_eval #(
    parameter int MAX_NODES = tsfe_pkg::MAX_NODES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tsfe_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output tsfe_pkg::out_item_t             out_data,
    input  logic                            cfg_we,
    input  logic [tsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsfe_pkg::DATA_W-1:0]     cfg_data
);
    import tsfe_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    tsfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_kind  (in_data.kind),
        .status   (status),
        .cmd      (cmd)
    );

    tsfe_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for trig_series_fit_and_eval: drives clear, add and evaluate
// words, predicts every series value in-line and checks it. Depends on tsfe_pkg and the RTL.
module tb;
    import tsfe_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int NODE_LIMIT = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_HARMONICS;
    logic [DATA_W-1:0] cfg_data = '0;

    trig_series_fit_and_eval DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    in_item_t pending_words[$];
    out_item_t series_results[$];
    int errors = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int holdoff_requests = 0;
    int holdoff_served = 0;
    int holdoff_left = 0;
    int stall_cycles = 0;

    logic signed [31:0] sine_tab [SINE_TABLE_DEPTH];
    logic [63:0] cos_acc [MEM_DEPTH];
    logic [63:0] sin_acc [MEM_DEPTH];
    int unsigned node_total = 0;
    logic [4:0] harm_m = 5'd0;
    logic [31:0] start_a = 32'd0;
    logic [31:0] inv_w = INV_WIDTH_RESET;

    function automatic logic [63:0] poly_sine(input logic [63:0] theta);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] dv [6];
        int j;
        dv = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        x2 = (theta * theta) >> 30;
        t = Q30_ONE;
        for (j = 0; j < 6; j++)
            t = Q30_ONE - ((x2 * t) >> 30) / dv[j];
        return (theta * t) >> 30;
    endfunction

    task automatic fill_sine_tab();
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] s;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
        begin
            p = 64'(i) << 22;
            r = p & (Q30_ONE - 1);
            if (p[30])
                r = Q30_ONE - r;
            s = (poly_sine((r * HALF_PI_Q30) >> 30) + 64'd8192) >> 14;
            sine_tab[i] = p[31] ? -32'(s) : 32'(s);
        end
    endtask

    function automatic longint trig_at(input logic [15:0] ph);
        return longint'(sine_tab[ph[15:6]]);
    endfunction

    function automatic logic [15:0] phase_of(input logic [31:0] x);
        logic [63:0] d;
        logic [63:0] prod;
        d = {{32{x[31]}}, x} - {{32{start_a[31]}}, start_a};
        prod = d * {32'd0, inv_w};
        return prod[31:16] - PHASE_HALF_TURN;
    endfunction

    function automatic longint coef_of(input logic [63:0] sum, input int unsigned n);
        logic [63:0] mag;
        logic [63:0] q;
        mag = sum[63] ? (64'd0 - sum) : sum;
        q = (mag / 64'(n)) >> 15;
        if (sum[63])
            return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    task automatic predict_word(input in_item_t w);
        logic [15:0] ph;
        logic [15:0] pk;
        longint yv;
        longint acc;
        longint v;
        out_item_t r;
        case (w.kind)
            KIND_CLEAR:
            begin
                for (int k = 0; k < MEM_DEPTH; k++)
                begin
                    cos_acc[k] = '0;
                    sin_acc[k] = '0;
                end
                node_total = 0;
            end
            KIND_ADD:
            begin
                if (node_total < NODE_LIMIT)
                begin
                    ph = phase_of(w.x);
                    yv = longint'(w.y);
                    for (int k = 0; k <= harm_m; k++)
                    begin
                        pk = 16'(k * ph);
                        cos_acc[k] += 64'(yv * trig_at(pk + PHASE_QUARTER_TURN));
                        sin_acc[k] += 64'(yv * trig_at(pk));
                    end
                    node_total++;
                end
            end
            KIND_EVAL:
            begin
                r = '0;
                if (node_total == 0 || harm_m > (node_total - 1) / 2)
                    r.error = 1'b1;
                else
                begin
                    ph = phase_of(w.x);
                    acc = coef_of(cos_acc[0], node_total) * 32768;
                    for (int k = 1; k <= harm_m; k++)
                    begin
                        pk = 16'(k * ph);
                        acc += coef_of(cos_acc[k], node_total) * trig_at(pk + PHASE_QUARTER_TURN);
                        acc += coef_of(sin_acc[k], node_total) * trig_at(pk);
                    end
                    v = acc >>> 16;
                    if (v > 64'sd2147483647)
                        v = 64'sd2147483647;
                    if (v < -64'sd2147483648)
                        v = -64'sd2147483648;
                    r.value = 32'(v);
                end
                series_results.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            predict_word(in_data);
        if (!in_valid || in_ready)
        begin
            if (rst_n && pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_words.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (out_valid && out_ready)
        begin
            if (series_results.size() == 0)
            begin
                $display("%0t unexpected word value=%h error=%b", $time, out_data.value,
                         out_data.error);
                errors++;
            end
            else
            begin
                want = series_results.pop_front();
                if (out_data.value !== want.value)
                begin
                    $display("%0t value mismatch: expected %h actual %h", $time, want.value,
                             out_data.value);
                    errors++;
                end
                if (out_data.error !== want.error)
                begin
                    $display("%0t error mismatch: expected %b actual %b", $time, want.error,
                             out_data.error);
                    errors++;
                end
            end
        end
        if (holdoff_served < holdoff_requests)
        begin
            holdoff_served++;
            holdoff_left = 600;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** trig_series_fit_and_eval: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic push_word(input logic [1:0] kind, input logic [31:0] x,
                             input logic [31:0] y);
        in_item_t w;
        w.kind = kind;
        w.x = x;
        w.y = y;
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || series_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HARMONICS: harm_m = val[4:0];
            REG_INTERVAL_START: start_a = val;
            default: inv_w = val;
        endcase
    endtask

    task automatic fit_sequence(input int m);
        int n;
        push_word(KIND_CLEAR, $urandom, $urandom);
        n = $urandom_range((2 * m > 3) ? 2 * m - 2 : 0, 2 * m + 12);
        for (int i = 0; i < n; i++)
        begin
            push_word(KIND_ADD, $urandom, ($urandom_range(0, 3) == 0) ? $urandom
                      : 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
            if ($urandom_range(0, 19) == 0)
                push_word(($urandom_range(0, 1) == 0) ? KIND_UNUSED : KIND_EVAL, $urandom, $urandom);
        end
        for (int i = 0; i < ((m >= 15) ? 2 : 4); i++)
            push_word(KIND_EVAL, $urandom, $urandom);
    endtask

    int phase_m [12] = '{0, 1, 2, 3, 31, 5, 0, 7, 2, 15, 1, 4};
    logic [31:0] start_pick;
    logic [31:0] width_pick;

    initial
    begin
        fill_sine_tab();
        for (int k = 0; k < MEM_DEPTH; k++)
        begin
            cos_acc[k] = '0;
            sin_acc[k] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        sender_idle_pct = 25;
        receiver_idle_pct = 84;

        push_word(KIND_EVAL, 32'd0, 32'd0);
        push_word(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(KIND_ADD, 32'd0, 32'h7FFF_FFFF);
        push_word(KIND_EVAL, 32'd0, 32'd0);
        push_word(KIND_ADD, 32'h8000_0000, 32'h8000_0000);
        push_word(KIND_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_word(KIND_ADD, 32'h0000_7FFF, 32'h0001_2345);
        push_word(KIND_EVAL, 32'h8000_0000, 32'd0);
        push_word(KIND_EVAL, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_word(KIND_EVAL, 32'h0000_8000, 32'd0);
        push_word(KIND_CLEAR, 32'd0, 32'd0);
        push_word(KIND_EVAL, 32'd0, 32'd0);
        push_word(KIND_ADD, 32'h0000_4000, 32'd0);
        push_word(KIND_EVAL, 32'h0000_4000, 32'd0);
        push_word(KIND_ADD, 32'hFFFF_0000, 32'h8000_0000);
        push_word(KIND_ADD, 32'h0000_C000, 32'h8000_0000);
        push_word(KIND_EVAL, 32'hFFFF_C000, 32'h7FFF_FFFF);
        wait_idle();

        write_reg(REG_HARMONICS, 32'd1);
        write_reg(REG_INTERVAL_START, 32'h8000_0000);
        write_reg(REG_INVERSE_WIDTH, 32'hFFFF_FFFF);
        push_word(KIND_CLEAR, 32'd0, 32'd0);
        for (int i = 0; i < NODE_LIMIT + 6; i++)
            push_word(KIND_ADD, $urandom, $urandom);
        for (int i = 0; i < 4; i++)
            push_word(KIND_EVAL, $urandom, $urandom);
        wait_idle();

        for (int p = 0; p < 12; p++)
        begin
            case (p % 3)
                0:
                begin
                    sender_idle_pct = 84;
                    receiver_idle_pct = 25;
                end
                1:
                begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
                default:
                begin
                    sender_idle_pct = 25;
                    receiver_idle_pct = 84;
                end
            endcase
            case (p % 4)
                0: start_pick = 32'h7FFF_FFFF;
                1: start_pick = 32'd0;
                2: start_pick = 32'h8000_0000;
                default: start_pick = $urandom;
            endcase
            case (p % 5)
                0: width_pick = 32'd1;
                1: width_pick = INV_WIDTH_RESET;
                2: width_pick = 32'hFFFF_FFFF;
                default: width_pick = $urandom_range(1, 32'hFFFF_FFFF);
            endcase
            write_reg(REG_HARMONICS, 32'(phase_m[p]));
            write_reg(REG_INTERVAL_START, start_pick);
            write_reg(REG_INVERSE_WIDTH, width_pick);
            if (p == 8)
                holdoff_requests++;
            for (int s = 0; s < ((phase_m[p] >= 15) ? 1 : 2); s++)
                fit_sequence(phase_m[p]);
            wait_idle();
        end

        while (pending_words.size() > 0 || in_valid || series_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** trig_series_fit_and_eval: PASSED **");
        else
            $display("** trig_series_fit_and_eval: FAILED **");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+sv
sv/tsfe_pkg.sv
sv/tsfe_ctrl.sv
sv/tsfe_datapath.sv
sv/trig_series_fit_and_eval.sv
tb/tb.sv
